FILE: rtl/rrts_pkg.sv
package rrts_pkg;

  localparam int MAX_TASKS = 8;
  localparam int TASK_AW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int WORD_W    = 32;
  localparam int NEXT_W    = 6;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_BLOCKED = 2'd3
  } task_st_t;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_BLOCK = 3'd1,
    OP_WAKE  = 3'd2,
    OP_ADD   = 3'd3,
    OP_START = 3'd4
  } op_t;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_FULL       = 2'd1;
  localparam logic [1:0] STAT_BAD_REASON = 2'd2;

  localparam logic [1:0] REASON_KBD = 2'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_SP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_KS = 1'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SAVE_RD,
    S_SAVE_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_BLK_RD,
    S_BLK_CHK,
    S_WAKE_RD,
    S_WAKE_CHK,
    S_START_RD,
    S_START_CHK,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [2:0]        func;
    logic [WORD_W-1:0] saved_stack_ptr;
    logic [1:0]        reason;
    logic [WORD_W-1:0] new_stack_ptr;
    logic [WORD_W-1:0] new_kernel_stack;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] next_stack_ptr;
    logic [WORD_W-1:0] next_kernel_stack;
    logic [NEXT_W-1:0] next_task;
    logic              to_idle;
    logic [1:0]        status;
  } out_word_t;

  typedef struct packed {
    task_st_t          status;
    logic [1:0]        cause;
    logic [WORD_W-1:0] stack_ptr;
    logic [WORD_W-1:0] kernel_stack;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [WORD_W-1:0] idle_stack_ptr;
    logic [WORD_W-1:0] idle_kernel_stack;
  } idle_cfg_t;

  typedef struct packed {
    logic               we;
    logic [TASK_AW-1:0] waddr;
    entry_t             wdata;
    logic               re;
    logic [TASK_AW-1:0] raddr;
  } mem_req_t;

endpackage

FILE: rtl/rrts_ram.sv
module rrts_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                         wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                         rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: rtl/rrts_ctrl.sv
module rrts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rrts_pkg::in_word_t  in_word,
  input  rrts_pkg::idle_cfg_t idle_cfg,
  output rrts_pkg::mem_req_t  mem_req,
  input  rrts_pkg::entry_t    mem_rdata,
  output logic                res_valid,
  input  logic                res_ready,
  output rrts_pkg::out_word_t res
);
  import rrts_pkg::*;

  ctrl_state_t        state_r, state_nxt;
  in_word_t           item_r, item_nxt;
  logic [TASK_AW-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic               idle_r, idle_nxt;
  logic [TASK_AW-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  out_word_t          res_r, res_nxt;
  entry_t             ent;
  logic               accept;

  function automatic logic [TASK_AW-1:0] wrap_inc(input logic [TASK_AW-1:0] i,
                                                  input logic [CNT_W-1:0]   tot);
    logic [CNT_W-1:0] s;
    s = CNT_W'(i) + CNT_W'(1);
    wrap_inc = (s == tot) ? '0 : TASK_AW'(s);
  endfunction

  function automatic out_word_t mk_res(input logic [WORD_W-1:0]  sp,
                                       input logic [WORD_W-1:0]  ks,
                                       input logic [TASK_AW-1:0] tsk,
                                       input logic               idl,
                                       input logic [1:0]         st);
    out_word_t r;
    r.next_stack_ptr    = sp;
    r.next_kernel_stack = ks;
    r.next_task         = NEXT_W'(tsk);
    r.to_idle           = idl;
    r.status            = st;
    mk_res = r;
  endfunction

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= '0;
      total_r <= '0;
      idle_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      total_r <= total_nxt;
      idle_r  <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    cur_nxt   = cur_r;
    total_nxt = total_r;
    idle_nxt  = idle_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    ent       = mem_rdata;
    mem_req   = '0;
    mem_req.raddr = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_word;
          res_nxt  = mk_res('0, '0, cur_r, idle_r, STAT_OK);
          state_nxt = S_DONE;
          case (in_word.func)
            OP_TICK: begin
              cnt_nxt = '0;
              if (!idle_r && (CNT_W'(cur_r) < total_r)) begin
                idx_nxt   = cur_r;
                state_nxt = S_SAVE_RD;
              end else if (total_r == '0) begin
                idle_nxt = 1'b1;
                res_nxt  = mk_res(idle_cfg.idle_stack_ptr, idle_cfg.idle_kernel_stack,
                                  '0, 1'b1, STAT_OK);
              end else begin
                idx_nxt   = wrap_inc(cur_r, total_r);
                state_nxt = S_SCAN_RD;
              end
            end
            OP_BLOCK: begin
              if (in_word.reason != REASON_KBD) begin
                res_nxt = mk_res('0, '0, cur_r, idle_r, STAT_BAD_REASON);
              end else if (!idle_r && (CNT_W'(cur_r) < total_r)) begin
                idx_nxt   = cur_r;
                state_nxt = S_BLK_RD;
              end
            end
            OP_WAKE: begin
              if (total_r != '0) begin
                idx_nxt   = '0;
                state_nxt = S_WAKE_RD;
              end
            end
            OP_ADD: begin
              if (total_r >= CNT_W'(MAX_TASKS)) begin
                res_nxt = mk_res('0, '0, cur_r, idle_r, STAT_FULL);
              end else begin
                mem_req.we                 = 1'b1;
                mem_req.waddr              = TASK_AW'(total_r);
                mem_req.wdata.status       = ST_READY;
                mem_req.wdata.cause        = REASON_KBD;
                mem_req.wdata.stack_ptr    = in_word.new_stack_ptr;
                mem_req.wdata.kernel_stack = in_word.new_kernel_stack;
                total_nxt                  = total_r + CNT_W'(1);
              end
            end
            OP_START: begin
              cur_nxt = '0;
              if (total_r == '0) begin
                idle_nxt = 1'b1;
                res_nxt  = mk_res(idle_cfg.idle_stack_ptr, idle_cfg.idle_kernel_stack,
                                  '0, 1'b1, STAT_OK);
              end else begin
                idx_nxt   = '0;
                state_nxt = S_START_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SAVE_RD: begin
        mem_req.re = 1'b1;
        state_nxt  = S_SAVE_WR;
      end

      S_SAVE_WR: begin
        ent.stack_ptr = item_r.saved_stack_ptr;
        if (mem_rdata.status == ST_RUNNING) begin
          ent.status = ST_READY;
        end
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = ent;
        idx_nxt       = wrap_inc(cur_r, total_r);
        state_nxt     = S_SCAN_RD;
      end

      S_SCAN_RD: begin
        mem_req.re = 1'b1;
        state_nxt  = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        if (mem_rdata.status == ST_READY) begin
          ent.status    = ST_RUNNING;
          mem_req.we    = 1'b1;
          mem_req.waddr = idx_r;
          mem_req.wdata = ent;
          cur_nxt       = idx_r;
          idle_nxt      = 1'b0;
          res_nxt       = mk_res(mem_rdata.stack_ptr, mem_rdata.kernel_stack,
                                 idx_r, 1'b0, STAT_OK);
          state_nxt     = S_DONE;
        end else if (cnt_r + CNT_W'(1) == total_r) begin
          idle_nxt  = 1'b1;
          res_nxt   = mk_res(idle_cfg.idle_stack_ptr, idle_cfg.idle_kernel_stack,
                             '0, 1'b1, STAT_OK);
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          idx_nxt   = wrap_inc(idx_r, total_r);
          state_nxt = S_SCAN_RD;
        end
      end

      S_BLK_RD: begin
        mem_req.re = 1'b1;
        state_nxt  = S_BLK_CHK;
      end

      S_BLK_CHK: begin
        if (mem_rdata.status == ST_RUNNING) begin
          ent.status    = ST_BLOCKED;
          ent.cause     = item_r.reason;
          mem_req.we    = 1'b1;
          mem_req.waddr = idx_r;
          mem_req.wdata = ent;
        end
        state_nxt = S_DONE;
      end

      S_WAKE_RD: begin
        mem_req.re = 1'b1;
        state_nxt  = S_WAKE_CHK;
      end

      S_WAKE_CHK: begin
        if (mem_rdata.status == ST_BLOCKED && mem_rdata.cause == item_r.reason) begin
          ent.status    = ST_READY;
          mem_req.we    = 1'b1;
          mem_req.waddr = idx_r;
          mem_req.wdata = ent;
        end
        if (CNT_W'(idx_r) + CNT_W'(1) == total_r) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + TASK_AW'(1);
          state_nxt = S_WAKE_RD;
        end
      end

      S_START_RD: begin
        mem_req.re = 1'b1;
        state_nxt  = S_START_CHK;
      end

      S_START_CHK: begin
        ent.status    = ST_RUNNING;
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = ent;
        idle_nxt      = 1'b0;
        res_nxt       = mk_res(mem_rdata.stack_ptr, mem_rdata.kernel_stack,
                               idx_r, 1'b0, STAT_OK);
        state_nxt     = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // current task lies inside the filled part of the table whenever the table is not empty
  a_cur_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r == '0) || (CNT_W'(cur_r) < total_r))
    else $error("current task index outside table");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_word.func == OP_ADD && total_r < CNT_W'(MAX_TASKS))
      |=> (total_r == $past(total_r) + CNT_W'(1)))
    else $error("add did not grow task count");

  a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we && state_r != S_IDLE) |-> (CNT_W'(mem_req.waddr) < total_r))
    else $error("table write beyond task count");

  a_res_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> ((res_r.to_idle == idle_r) &&
                   (res_r.to_idle || res_r.next_task == NEXT_W'(cur_r))))
    else $error("result disagrees with scheduler state");

endmodule

FILE: rtl/round_robin_task_scheduler.sv
// Round-robin task scheduler. Each request word (tick, block, wake, add, start)
// gives exactly one result word. Task entries live in an 8-entry synchronous
// table memory, visited one entry at a time by a read state and then a check
// or write state. Add, block with bad reason and full table finish straight
// from idle; the longest request is a tick that saves the outgoing task and
// then scans the whole table, and wake visits every task in the table. The
// next request is accepted once the current result has moved into the output
// register, even while that result still waits there. The idle task's stack
// pointer and kernel stack base come from cfg registers 0 and 1; the user must
// write them only while the block is quiet; the block does not enforce this.
module round_robin_task_scheduler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rrts_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rrts_pkg::out_word_t                out_data,
  input  logic                               cfg_we,
  input  logic [rrts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rrts_pkg::WORD_W-1:0]        cfg_wdata
);
  import rrts_pkg::*;

  idle_cfg_t idle_cfg_r;
  mem_req_t  mem_req;
  entry_t    mem_rdata;
  logic      res_valid;
  logic      res_ready;
  out_word_t res;
  logic      out_valid_r;
  out_word_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDLE_SP: idle_cfg_r.idle_stack_ptr    <= cfg_wdata;
        CFG_IDLE_KS: idle_cfg_r.idle_kernel_stack <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  rrts_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_data),
    .idle_cfg  (idle_cfg_r),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rrts_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES = 2 * MAX_TASKS + 4;
  localparam logic [2:0] FUNC_LAST = '1;
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0] cfg_wdata = '0;

  round_robin_task_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scheduler shadow state
  task_st_t slot_state[MAX_TASKS];
  logic [1:0] slot_cause[MAX_TASKS];
  logic [WORD_W-1:0] slot_sp[MAX_TASKS];
  logic [WORD_W-1:0] slot_ks[MAX_TASKS];
  int cur_slot;
  int slot_count;
  bit idle_running;
  logic [WORD_W-1:0] idle_sp;
  logic [WORD_W-1:0] idle_ks;

  out_word_t switch_queue[$];
  out_word_t want;

  int errors = 0;
  int cycles = 0;
  int words_sent = 0;
  int words_seen = 0;
  int idle_picks = 0;
  int full_hits = 0;
  int bad_reasons = 0;
  int cfg_writes = 0;

  bit tx_fast = 1'b0;
  bit rx_fast = 1'b0;
  int rx_hold = 0;
  int rx_pick;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WORD_W-1:0] rand_word32();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return ALL_ONES;
    return $urandom;
  endfunction

  function automatic out_word_t plain_result(logic [1:0] st);
    out_word_t r;
    r = '0;
    r.next_task = NEXT_W'(cur_slot);
    r.to_idle = idle_running;
    r.status = st;
    return r;
  endfunction

  function automatic out_word_t dispatch_slot(int idx);
    out_word_t r;
    r = '0;
    slot_state[idx] = ST_RUNNING;
    cur_slot = idx;
    idle_running = 1'b0;
    r.next_stack_ptr = slot_sp[idx];
    r.next_kernel_stack = slot_ks[idx];
    r.next_task = NEXT_W'(idx);
    r.status = STAT_OK;
    return r;
  endfunction

  function automatic out_word_t dispatch_idle();
    out_word_t r;
    r = '0;
    idle_running = 1'b1;
    r.next_stack_ptr = idle_sp;
    r.next_kernel_stack = idle_ks;
    r.to_idle = 1'b1;
    r.status = STAT_OK;
    return r;
  endfunction

  function automatic out_word_t predict_switch(in_word_t w);
    out_word_t r;
    int idx;
    bit found;
    found = 1'b0;
    r = plain_result(STAT_OK);
    case (w.func)
      OP_TICK: begin
        if (!idle_running && cur_slot < slot_count) begin
          slot_sp[cur_slot] = w.saved_stack_ptr;
          if (slot_state[cur_slot] == ST_RUNNING) slot_state[cur_slot] = ST_READY;
        end
        for (int i = 0; i < slot_count; i++) begin
          idx = (cur_slot + i + 1) % slot_count;
          if (!found && slot_state[idx] == ST_READY) begin
            r = dispatch_slot(idx);
            found = 1'b1;
          end
        end
        if (!found) r = dispatch_idle();
      end
      OP_BLOCK: begin
        if (w.reason != REASON_KBD) begin
          r = plain_result(STAT_BAD_REASON);
        end else begin
          if (!idle_running && cur_slot < slot_count &&
              slot_state[cur_slot] == ST_RUNNING) begin
            slot_state[cur_slot] = ST_BLOCKED;
            slot_cause[cur_slot] = w.reason;
          end
          r = plain_result(STAT_OK);
        end
      end
      OP_WAKE: begin
        for (int i = 0; i < slot_count; i++)
          if (slot_state[i] == ST_BLOCKED && slot_cause[i] == w.reason)
            slot_state[i] = ST_READY;
        r = plain_result(STAT_OK);
      end
      OP_ADD: begin
        if (slot_count >= MAX_TASKS) begin
          r = plain_result(STAT_FULL);
        end else begin
          slot_sp[slot_count] = w.new_stack_ptr;
          slot_ks[slot_count] = w.new_kernel_stack;
          slot_cause[slot_count] = REASON_KBD;
          slot_state[slot_count] = ST_READY;
          slot_count++;
          r = plain_result(STAT_OK);
        end
      end
      OP_START: begin
        cur_slot = 0;
        if (slot_count == 0) r = dispatch_idle();
        else r = dispatch_slot(0);
      end
      default: r = plain_result(STAT_OK);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] exp_val);
    if (errors < 40)
      $display("ERROR result %0d %s: got %h want %h", words_seen, field, got, exp_val);
    errors++;
  endtask

  task automatic send_request(in_word_t w);
    int gap;
    gap = tx_fast ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = w;
    do @(posedge clk); while (!in_ready);
    switch_queue.push_back(predict_switch(w));
    words_sent++;
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (switch_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_IDLE_SP) idle_sp = val;
    else idle_ks = val;
    cfg_writes++;
  endtask

  function automatic in_word_t make_req(op_t f, logic [1:0] rsn);
    in_word_t w;
    w.func = f;
    w.saved_stack_ptr = rand_word32();
    w.reason = rsn;
    w.new_stack_ptr = rand_word32();
    w.new_kernel_stack = rand_word32();
    return w;
  endfunction

  function automatic in_word_t rand_request();
    in_word_t w;
    int r;
    r = $urandom_range(0, 99);
    if (r < 36) w = make_req(OP_TICK, 2'($urandom_range(0, 3)));
    else if (r < 58) w = make_req(OP_BLOCK, REASON_KBD);
    else if (r < 62) w = make_req(OP_BLOCK, 2'($urandom_range(1, 3)));
    else if (r < 76) w = make_req(OP_WAKE, REASON_KBD);
    else if (r < 80) w = make_req(OP_WAKE, 2'($urandom_range(1, 3)));
    else if (r < 86) w = make_req(OP_ADD, 2'($urandom_range(0, 3)));
    else if (r < 94) w = make_req(OP_START, 2'($urandom_range(0, 3)));
    else begin
      w = make_req(OP_TICK, 2'($urandom_range(0, 3)));
      w.func = 3'($urandom_range(int'(OP_START) + 1, int'(FUNC_LAST)));
    end
    return w;
  endfunction

  // receiver: random stalls, most short, a few long
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready = 1'b0;
    end else if (rx_fast) begin
      out_ready = 1'b1;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 60) begin
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b0;
        rx_hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (switch_queue.size() == 0) begin
        report_mismatch("unexpected word", out_data.next_stack_ptr, '0);
      end else begin
        want = switch_queue.pop_front();
        if (out_data.next_stack_ptr !== want.next_stack_ptr)
          report_mismatch("next_stack_ptr", out_data.next_stack_ptr, want.next_stack_ptr);
        if (out_data.next_kernel_stack !== want.next_kernel_stack)
          report_mismatch("next_kernel_stack", out_data.next_kernel_stack,
                          want.next_kernel_stack);
        if (out_data.next_task !== want.next_task)
          report_mismatch("next_task", WORD_W'(out_data.next_task), WORD_W'(want.next_task));
        if (out_data.to_idle !== want.to_idle)
          report_mismatch("to_idle", WORD_W'(out_data.to_idle), WORD_W'(want.to_idle));
        if (out_data.status !== want.status)
          report_mismatch("status", WORD_W'(out_data.status), WORD_W'(want.status));
        if (want.to_idle) idle_picks++;
        if (want.status == STAT_FULL) full_hits++;
        if (want.status == STAT_BAD_REASON) bad_reasons++;
      end
      words_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout with %0d words outstanding", switch_queue.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_empty_table();
    in_word_t w;
    send_request(make_req(OP_TICK, REASON_KBD));
    send_request(make_req(OP_START, REASON_KBD));
    send_request(make_req(OP_BLOCK, REASON_KBD));
    for (int r = 1; r < 4; r++) send_request(make_req(OP_BLOCK, 2'(r)));
    send_request(make_req(OP_WAKE, REASON_KBD));
    send_request(make_req(OP_WAKE, 2'b11));
    w = make_req(OP_TICK, REASON_KBD);
    w.func = FUNC_LAST;
    send_request(w);
    w.func = 3'(int'(OP_START) + 1);
    send_request(w);
    wait_quiet();
  endtask

  task automatic test_idle_config();
    write_cfg(CFG_IDLE_SP, ALL_ONES);
    write_cfg(CFG_IDLE_KS, '0);
    send_request(make_req(OP_TICK, REASON_KBD));
    wait_quiet();
    write_cfg(CFG_IDLE_SP, '0);
    write_cfg(CFG_IDLE_KS, ALL_ONES);
    send_request(make_req(OP_TICK, REASON_KBD));
    wait_quiet();
  endtask

  task automatic test_fill_and_switch();
    in_word_t w;
    w = make_req(OP_ADD, REASON_KBD);
    w.new_stack_ptr = ALL_ONES;
    w.new_kernel_stack = ALL_ONES;
    send_request(w);
    // idle is running: this saved pointer must be dropped
    w = make_req(OP_TICK, REASON_KBD);
    w.saved_stack_ptr = ALL_ONES;
    send_request(w);
    w.saved_stack_ptr = '0;
    send_request(w);
    w = make_req(OP_ADD, REASON_KBD);
    w.new_stack_ptr = '0;
    w.new_kernel_stack = '0;
    send_request(w);
    for (int i = 2; i < MAX_TASKS; i++) send_request(make_req(OP_ADD, REASON_KBD));
    send_request(make_req(OP_ADD, REASON_KBD));
    send_request(make_req(OP_START, REASON_KBD));
    send_request(make_req(OP_BLOCK, REASON_KBD));
    send_request(make_req(OP_BLOCK, REASON_KBD));
    send_request(make_req(OP_TICK, REASON_KBD));
    send_request(make_req(OP_WAKE, REASON_KBD));
    send_request(make_req(OP_TICK, REASON_KBD));
    wait_quiet();
  endtask

  task automatic test_random_mix();
    for (int ph = 0; ph < 4; ph++) begin
      tx_fast = (ph == 1);
      rx_fast = (ph == 2);
      case (ph)
        0: begin
          write_cfg(CFG_IDLE_SP, $urandom);
          write_cfg(CFG_IDLE_KS, $urandom);
        end
        1: begin
          write_cfg(CFG_IDLE_SP, ALL_ONES);
          write_cfg(CFG_IDLE_KS, ALL_ONES);
        end
        2: begin
          write_cfg(CFG_IDLE_SP, '0);
          write_cfg(CFG_IDLE_KS, '0);
        end
        default: begin
          write_cfg(CFG_IDLE_SP, rand_word32());
          write_cfg(CFG_IDLE_KS, rand_word32());
        end
      endcase
      for (int n = 0; n < 500; n++) begin
        // stall the sender until the result path is empty
        if (n == 250 && ph != 1) wait_quiet();
        send_request(rand_request());
      end
      wait_quiet();
    end
    tx_fast = 1'b0;
    rx_fast = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      slot_state[i] = ST_EMPTY;
      slot_cause[i] = REASON_KBD;
      slot_sp[i] = '0;
      slot_ks[i] = '0;
    end
    cur_slot = 0;
    slot_count = 0;
    idle_running = 1'b0;
    idle_sp = '0;
    idle_ks = '0;
    rst_n = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_idle_config();
    test_fill_and_switch();
    test_random_mix();

    wait_quiet();
    $display("Sent %0d requests, checked %0d results over %0d cycles",
             words_sent, words_seen, cycles);
    $display("Idle picks %0d, table-full %0d, bad reason %0d, idle cfg writes %0d",
             idle_picks, full_hits, bad_reasons, cfg_writes);
    if (errors == 0 && switch_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: round_robin_task_scheduler.f
rtl/rrts_pkg.sv
rtl/rrts_ram.sv
rtl/rrts_ctrl.sv
rtl/round_robin_task_scheduler.sv
tb/tb_top.sv
